// File: rtl/lrfp_pkg.sv
// Shared codes, constants and types of the length-encoded row field parser.
package lrfp_pkg;

  localparam int CFG_W = 13;

  // parser phases
  localparam logic [1:0] PH_PREFIX  = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_PREFIX  = 2'd0;
  localparam logic [1:0] KIND_NULL    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_CORRUPT = 2'd3;

  // length-encoded integer markers
  localparam logic [7:0] LEN_NULL    = 8'hFB;
  localparam logic [7:0] LEN_2BYTE   = 8'hFC;
  localparam logic [7:0] LEN_3BYTE   = 8'hFD;
  localparam logic [7:0] LEN_8BYTE   = 8'hFE;
  localparam logic [7:0] LEN_INVALID = 8'hFF;

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  prefix_left;
    logic [2:0]  prefix_pos;
    logic [63:0] length_accum;
    logic [63:0] payload_left;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] field_length;
    logic        col_done;
    logic        bad_prefix;
  } step_info_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:        PH_PREFIX,
    prefix_left:  4'd0,
    prefix_pos:   3'd0,
    length_accum: 64'd0,
    payload_left: 64'd0
  };

endpackage

// File: rtl/lrfp_ifs.sv
// Valid/ready channel interfaces for the parser's byte input and tagged result.
interface lrfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lrfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] column;
  logic [7:0]  out_byte;
  logic [63:0] field_length;
  logic        column_done;
  logic        row_done;
  logic [31:0] consumed;

  modport source (output valid, output kind, output column, output out_byte,
                  output field_length, output column_done, output row_done,
                  output consumed, input ready);
  modport sink   (input valid, input kind, input column, input out_byte,
                  input field_length, input column_done, input row_done,
                  input consumed, output ready);
endinterface

// File: rtl/lenenc_row_field_parser.sv
// Top level: length-encoded row parser that tags each row byte with column and role.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+------------------------------------------------
//  in_ch   | in  | valid/ready     | in_byte, in_last
//  out_ch  | out | valid/ready     | kind, column, out_byte, field_length,
//          |     |                 | column_done, row_done, consumed
//  cfg     | in  | cfg_we          | cfg_wdata (column_count)
//
// One byte per cycle sustained while the receiver stays ready; each byte goes through
// the input register, then through the decode into the result register.
// The row state (phase, length accumulator, payload and column counters) updates in
// the cycle a byte leaves the input register, so the next byte sees it directly.
// rst_n is synchronous, active low; it empties both stages and sets column_count to 1.
// A stalled result holds the input register; a new byte is taken whenever the input
// register empties or advances in the same cycle.
module lenenc_row_field_parser #(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lrfp_in_if.sink                      in_ch,
  lrfp_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [lrfp_pkg::CFG_W-1:0]   cfg_wdata
);
  import lrfp_pkg::*;

  // column counter holds 0..MAX_COLUMNS
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

  // configuration, clamped to 1..MAX_COLUMNS on write
  logic [CNT_W-1:0] cols_r, cols_nxt;
  logic [31:0]      cfg_ext, cfg_clamp;

  // input register
  logic       s0_valid_r;
  logic [7:0] s0_byte_r;
  logic       s0_last_r;
  logic       advance;

  // row state
  parse_state_t     parse_r, parse_nxt, step_nxt;
  step_info_t       info;
  logic [CNT_W-1:0] col_idx_r, col_idx_nxt;
  logic [31:0]      byte_cnt_r, byte_cnt_nxt, byte_cnt_inc;
  logic [CNT_W:0]   idx_inc;
  logic [CNT_W+11:0] col_ext;

  // per-byte result
  logic corrupt, col_done, row_done;

  // result register
  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [11:0] column_r;
  logic [7:0]  byte_r;
  logic [63:0] flen_r;
  logic        col_done_r, row_done_r;
  logic [31:0] consumed_r;

  always_comb begin
    cfg_ext = 32'(cfg_wdata);
    if (cfg_ext == 32'd0) begin
      cfg_clamp = 32'd1;
    end else if (cfg_ext > 32'(MAX_COLUMNS)) begin
      cfg_clamp = 32'(MAX_COLUMNS);
    end else begin
      cfg_clamp = cfg_ext;
    end
    cols_nxt = cfg_clamp[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CNT_W'(1);
    end else if (cfg_we) begin
      cols_r <= cols_nxt;
    end
  end

  // advance when the result register is free or drains this cycle
  assign advance     = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s0_byte_r <= in_ch.in_byte;
      s0_last_r <= in_ch.in_last;
    end
  end

  lrfp_step u_step (
    .st      (parse_r),
    .byte_in (s0_byte_r),
    .st_nxt  (step_nxt),
    .info    (info)
  );

  always_comb begin
    idx_inc      = {1'b0, col_idx_r} + {{CNT_W{1'b0}}, 1'b1};
    byte_cnt_inc = (byte_cnt_r == 32'hFFFF_FFFF) ? byte_cnt_r : byte_cnt_r + 32'd1;

    // a bad prefix, or a buffer ending mid-column, corrupts the row
    corrupt  = info.bad_prefix || (!info.col_done && s0_last_r);
    col_done = info.col_done && !corrupt;
    row_done = corrupt || (col_done && ((idx_inc >= {1'b0, cols_r}) || s0_last_r));

    // drop all row state at row end
    if (row_done) begin
      parse_nxt    = PARSE_RESET;
      col_idx_nxt  = '0;
      byte_cnt_nxt = 32'd0;
    end else begin
      parse_nxt    = step_nxt;
      col_idx_nxt  = col_done ? idx_inc[CNT_W-1:0] : col_idx_r;
      byte_cnt_nxt = byte_cnt_inc;
    end

    col_ext = {12'd0, col_idx_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_r    <= PARSE_RESET;
      col_idx_r  <= '0;
      byte_cnt_r <= 32'd0;
    end else if (advance) begin
      parse_r    <= parse_nxt;
      col_idx_r  <= col_idx_nxt;
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r     <= corrupt ? KIND_CORRUPT : info.kind;
      column_r   <= col_ext[11:0];
      byte_r     <= s0_byte_r;
      flen_r     <= corrupt ? 64'd0 : info.field_length;
      col_done_r <= col_done;
      row_done_r <= row_done;
      consumed_r <= row_done ? byte_cnt_inc : 32'd0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.column       = column_r;
  assign out_ch.out_byte     = byte_r;
  assign out_ch.field_length = flen_r;
  assign out_ch.column_done  = col_done_r;
  assign out_ch.row_done     = row_done_r;
  assign out_ch.consumed     = consumed_r;

endmodule

// File: rtl/lrfp_step.sv
// Per-byte decode of the length prefix, length bytes and payload of one column.
module lrfp_step (
  input  lrfp_pkg::parse_state_t st,
  input  logic [7:0]             byte_in,
  output lrfp_pkg::parse_state_t st_nxt,
  output lrfp_pkg::step_info_t   info
);
  import lrfp_pkg::*;

  logic [63:0] accum_new;
  logic [3:0]  left_new;
  logic [63:0] pay_new;

  always_comb begin
    accum_new = st.length_accum | ({56'd0, byte_in} << {st.prefix_pos, 3'b000});
    left_new  = (st.prefix_left != 4'd0) ? st.prefix_left - 4'd1 : 4'd0;
    pay_new   = (st.payload_left != 64'd0) ? st.payload_left - 64'd1 : 64'd0;

    st_nxt = st;
    info   = '{kind: KIND_PREFIX, field_length: 64'd0, col_done: 1'b0,
               bad_prefix: 1'b0};

    case (st.phase)
      PH_PREFIX: begin
        if (byte_in < LEN_NULL) begin
          info.field_length = {56'd0, byte_in};
          if (byte_in == 8'd0) begin
            info.col_done = 1'b1;
          end else begin
            st_nxt.payload_left = {56'd0, byte_in};
            st_nxt.phase        = PH_PAYLOAD;
          end
        end else if (byte_in == LEN_NULL) begin
          info.kind     = KIND_NULL;
          info.col_done = 1'b1;
        end else if (byte_in == LEN_INVALID) begin
          info.bad_prefix = 1'b1;
        end else begin
          st_nxt.prefix_left  = (byte_in == LEN_2BYTE) ? 4'd2 :
                                (byte_in == LEN_3BYTE) ? 4'd3 : 4'd8;
          st_nxt.prefix_pos   = 3'd0;
          st_nxt.length_accum = 64'd0;
          st_nxt.phase        = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        st_nxt.length_accum = accum_new;
        st_nxt.prefix_pos   = st.prefix_pos + 3'd1;
        st_nxt.prefix_left  = left_new;
        if (left_new == 4'd0) begin
          info.field_length = accum_new;
          if (accum_new == 64'd0) begin
            info.col_done = 1'b1;
            st_nxt.phase  = PH_PREFIX;
          end else begin
            st_nxt.payload_left = accum_new;
            st_nxt.phase        = PH_PAYLOAD;
          end
        end
      end
      default: begin
        info.kind           = KIND_PAYLOAD;
        st_nxt.payload_left = pay_new;
        if (pay_new == 64'd0) begin
          info.col_done = 1'b1;
          st_nxt.phase  = PH_PREFIX;
        end
      end
    endcase
  end

endmodule

// File: rtl/lrfp_checker.sv
// Port-level assertions for the row parser, bound to the top level.
module lrfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [63:0] out_field_length,
  input logic        out_column_done,
  input logic        out_row_done,
  input logic [31:0] out_consumed
);
  import lrfp_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_consumed) && $stable(out_row_done))
    else $error("stalled result changed");

  a_corrupt_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CORRUPT |->
      out_row_done && !out_column_done && out_field_length == 64'd0)
    else $error("corrupt byte did not end the row cleanly");

  a_clean_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_done && out_kind != KIND_CORRUPT |->
      out_column_done && out_consumed != 32'd0)
    else $error("row ended without completing a column");

  a_consumed_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row_done |-> out_consumed == 32'd0)
    else $error("consumed reported mid-row");

endmodule

bind lenenc_row_field_parser lrfp_checker u_lrfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_field_length (out_ch.field_length),
  .out_column_done  (out_ch.column_done),
  .out_row_done     (out_ch.row_done),
  .out_consumed     (out_ch.consumed)
);

// File: test/lrfp_result_checker.sv
// Result checker: predicts each tagged byte of the row parser and compares it with the block.
`timescale 1ns / 1ps

module lrfp_result_checker #(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lrfp_in_if                         in_mon,
  lrfp_out_if                        out_mon,
  input  logic                       cfg_we,
  input  logic [lrfp_pkg::CFG_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         outstanding
);
  import lrfp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] column;
    logic [7:0]  data;
    logic [63:0] field_length;
    logic        column_done;
    logic        row_done;
    logic [31:0] consumed;
  } tagged_byte_t;

  tagged_byte_t tagged_q[$];
  int           fail_count;

  // row parser state as seen from outside
  logic [CFG_W-1:0] col_count_reg;
  logic [1:0]       ph;
  logic [3:0]       pfx_left;
  logic [2:0]       pfx_pos;
  logic [63:0]      len_acc;
  logic [63:0]      pay_left;
  int unsigned      col_idx;
  logic [31:0]      row_bytes;

  function automatic void clear_row();
    ph        = PH_PREFIX;
    pfx_left  = '0;
    pfx_pos   = '0;
    len_acc   = '0;
    pay_left  = '0;
    col_idx   = 0;
    row_bytes = '0;
  endfunction

  function automatic tagged_byte_t tag_byte(input logic [7:0] b, input logic last);
    tagged_byte_t r;
    int unsigned  cols;
    logic         done;
    logic         corrupt;
    logic         ends;
    r         = '0;
    r.kind    = KIND_PREFIX;
    r.column  = 12'(col_idx);
    r.data    = b;
    done      = 1'b0;
    corrupt   = 1'b0;
    ends      = 1'b0;
    if (col_count_reg == '0) cols = 1;
    else if (col_count_reg > MAX_COLUMNS) cols = MAX_COLUMNS;
    else cols = col_count_reg;
    if (row_bytes != '1) row_bytes = row_bytes + 1;

    case (ph)
      PH_PREFIX: begin
        if (b < LEN_NULL) begin
          r.field_length = 64'(b);
          if (b == 8'd0) begin
            done = 1'b1;
          end else begin
            pay_left = 64'(b);
            ph       = PH_PAYLOAD;
          end
        end else if (b == LEN_NULL) begin
          r.kind = KIND_NULL;
          done   = 1'b1;
        end else if (b == LEN_INVALID) begin
          corrupt = 1'b1;
        end else begin
          pfx_left = (b == LEN_2BYTE) ? 4'd2 : (b == LEN_3BYTE) ? 4'd3 : 4'd8;
          pfx_pos  = '0;
          len_acc  = '0;
          ph       = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        len_acc = len_acc | (64'(b) << {pfx_pos, 3'b000});
        pfx_pos = pfx_pos + 1;
        if (pfx_left != 0) pfx_left = pfx_left - 1;
        if (pfx_left == 0) begin
          r.field_length = len_acc;
          if (len_acc == 0) begin
            done = 1'b1;
            ph   = PH_PREFIX;
          end else begin
            pay_left = len_acc;
            ph       = PH_PAYLOAD;
          end
        end
      end
      default: begin
        r.kind = KIND_PAYLOAD;
        if (pay_left != 0) pay_left = pay_left - 1;
        if (pay_left == 0) begin
          done = 1'b1;
          ph   = PH_PREFIX;
        end
      end
    endcase

    if (corrupt) begin
      ends = 1'b1;
    end else if (done) begin
      ph      = PH_PREFIX;
      col_idx = col_idx + 1;
      if (col_idx >= cols || last) ends = 1'b1;
    end else if (last) begin
      // buffer ran out inside a prefix or payload
      corrupt = 1'b1;
      ends    = 1'b1;
    end

    if (corrupt) begin
      r.kind         = KIND_CORRUPT;
      r.field_length = '0;
      done           = 1'b0;
    end
    r.column_done = done;
    r.row_done    = ends;
    r.consumed    = ends ? row_bytes : 32'd0;
    if (ends) clear_row();
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fail_count++;
    $display("%0t checker: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic check_result();
    tagged_byte_t want;
    if (tagged_q.size() == 0) begin
      report("result with nothing outstanding, byte", 64'(out_mon.out_byte), 64'd0);
    end else begin
      want = tagged_q.pop_front();
      if (out_mon.kind !== want.kind) report("kind", 64'(out_mon.kind), 64'(want.kind));
      if (out_mon.column !== want.column)
        report("column", 64'(out_mon.column), 64'(want.column));
      if (out_mon.out_byte !== want.data)
        report("out_byte", 64'(out_mon.out_byte), 64'(want.data));
      if (out_mon.field_length !== want.field_length)
        report("field_length", out_mon.field_length, want.field_length);
      if (out_mon.column_done !== want.column_done)
        report("column_done", 64'(out_mon.column_done), 64'(want.column_done));
      if (out_mon.row_done !== want.row_done)
        report("row_done", 64'(out_mon.row_done), 64'(want.row_done));
      if (out_mon.consumed !== want.consumed)
        report("consumed", 64'(out_mon.consumed), 64'(want.consumed));
    end
  endtask

  initial begin
    fail_count    = 0;
    col_count_reg = 1;
    clear_row();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      col_count_reg = 1;
      clear_row();
      tagged_q.delete();
    end else begin
      if (cfg_we) col_count_reg = cfg_wdata;
      // compare before queueing, so a stray result is never matched to a fresh byte
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        tagged_q.push_back(tag_byte(in_mon.in_byte, in_mon.in_last));
    end
    mismatches  <= fail_count;
    outstanding <= tagged_q.size();
  end

endmodule

// File: test/tb.sv
// Testbench top: drives row buffers into the parser under random flow control and gives the verdict.
`timescale 1ns / 1ps

module tb;
  import lrfp_pkg::*;

  localparam int MAX_COLUMNS = 4096;
  localparam int IDLE_LIMIT  = 3000;  // cycles with no transfer on either channel
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off used to back up the block

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } row_byte_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lrfp_in_if  in_ch();
  lrfp_out_if out_ch();

  int        mismatches;
  int        outstanding;
  int        idle_cycles;
  int        phase_bytes;
  int        eff_cols;
  bit        full_rate;
  bit        hold_req;
  row_byte_t row_q[$];

  lenenc_row_field_parser #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lrfp_result_checker #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random ready pattern; hold off for a long stretch on request,
  // and stay ready throughout a full-rate phase.
  initial begin
    int run;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (full_rate) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 30);
        out_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
        out_ch.ready <= 1'b0;
        // ready goes low between runs, so it never gets two updates in one step
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic last = 1'b0);
    row_q.push_back('{data: b, last: last});
  endtask

  task automatic add_payload(input int n);
    repeat (n) add_byte(8'($urandom));
  endtask

  // Append a multi-byte length prefix: marker, then the little-endian length.
  task automatic add_length(input logic [7:0] marker, input logic [63:0] n);
    int nbytes;
    nbytes = (marker == LEN_2BYTE) ? 2 : (marker == LEN_3BYTE) ? 3 : 8;
    add_byte(marker);
    for (int i = 0; i < nbytes; i++) add_byte(n[8*i +: 8]);
  endtask

  function automatic logic [7:0] pick_marker();
    case ($urandom_range(0, 2))
      0:       return LEN_2BYTE;
      1:       return LEN_3BYTE;
      default: return LEN_8BYTE;
    endcase
  endfunction

  // One complete column: short, NULL, empty, multi-byte length or long payload.
  task automatic add_column();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = $urandom_range(1, 8);
      add_byte(8'(n));
      add_payload(n);
    end else if (pick < 55) begin
      add_byte(LEN_NULL);
    end else if (pick < 65) begin
      add_byte(8'd0);
    end else if (pick < 95) begin
      n = $urandom_range(0, 12);
      add_length(pick_marker(), 64'(n));
      add_payload(n);
    end else begin
      n = $urandom_range(200, 250);
      add_byte(8'(n));
      add_payload(n);
    end
  endtask

  // Build one row buffer. Most rows are well formed with random content; the
  // rest are cut short, promise more payload than they carry, hit the invalid
  // marker, or are plain noise.
  task automatic build_row();
    int shape;
    int ncols;
    int cut;
    row_q.delete();
    shape = $urandom_range(0, 99);
    ncols = (eff_cols <= 6 && $urandom_range(0, 3) != 0) ? eff_cols : $urandom_range(1, 5);
    repeat (ncols) add_column();
    if (shape < 70) begin
      // short of the column count the buffer has to end the row itself
      if (ncols < eff_cols || $urandom_range(0, 1) == 1) row_q[$].last = 1'b1;
    end else if (shape < 80) begin
      cut = $urandom_range(0, row_q.size() - 1);
      while (row_q.size() > cut + 1) void'(row_q.pop_back());
      row_q[$].last = 1'b1;
    end else if (shape < 88) begin
      add_length(pick_marker(), {$urandom, $urandom});
      add_payload($urandom_range(0, 3));
      row_q[$].last = 1'b1;
    end else if (shape < 94) begin
      add_byte(LEN_INVALID);
    end else begin
      row_q.delete();
      add_payload($urandom_range(1, 12));
      row_q[$].last = 1'b1;
    end
  endtask

  // Offer each byte of row_q; keep valid high across back-to-back transfers.
  task automatic send_row();
    int gap;
    foreach (row_q[i]) begin
      gap = full_rate ? 0 : pick_gap();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid   <= 1'b1;
      in_ch.in_byte <= row_q[i].data;
      in_ch.in_last <= row_q[i].last;
      do @(posedge clk); while (!in_ch.ready);
      phase_bytes++;
    end
  endtask

  // Drop valid and wait until every expected result has been seen.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write column_count only with the block idle; let the pipeline settle first.
  task automatic write_column_count(input logic [CFG_W-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    eff_cols = (v == '0) ? 1 : (v > MAX_COLUMNS) ? MAX_COLUMNS : int'(v);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cc, input int target);
    write_column_count(cc);
    phase_bytes = 0;
    while (phase_bytes < target) begin
      build_row();
      send_row();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    full_rate     = 1'b0;
    hold_req      = 1'b0;
    eff_cols      = 1;
    phase_bytes   = 0;
    idle_cycles   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset column count of one, so each column ends its row.
    row_q.delete();
    add_byte(8'd0);                   // empty column closes the row by count
    add_byte(LEN_NULL, 1'b1);         // NULL marker on the last byte
    add_byte(LEN_INVALID);            // invalid marker corrupts the row
    add_byte(8'd1);
    add_byte(8'h5A);                  // one-byte payload
    add_byte(8'hFA);
    add_byte(8'hA5, 1'b1);            // buffer ends inside the payload
    add_length(LEN_2BYTE, 64'd1);
    add_byte(8'hC3);
    add_length(LEN_3BYTE, 64'd0);     // empty column via a three-byte length
    add_byte(LEN_8BYTE);
    add_byte(8'h12, 1'b1);            // buffer ends inside the length prefix
    add_length(LEN_8BYTE, '1);        // largest length, then cut short
    add_byte(8'hFF, 1'b1);
    send_row();

    // Random phases over a spread of column counts, extremes included.
    run_phase(13'd3, 60);

    full_rate = 1'b1;                 // no idling on either side
    run_phase(13'd0, 50);
    full_rate = 1'b0;

    // Back the block up: hold off the receiver while the sender keeps offering.
    drain();
    full_rate = 1'b1;
    hold_req  = 1'b1;
    run_phase(13'd5, 60);
    full_rate = 1'b0;

    // Largest count clamps to MAX_COLUMNS.
    run_phase('1, 30);

    run_phase(13'd2, 50);
    run_phase(13'd4097, 40);
    run_phase(13'd1, 50);
    run_phase(13'd4, 60);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lrfp_pkg.sv
rtl/lrfp_ifs.sv
rtl/lrfp_step.sv
rtl/lenenc_row_field_parser.sv
rtl/lrfp_checker.sv
test/lrfp_result_checker.sv
test/tb.sv
